// ----- rtl/chki_pkg.sv -----
// Package for the chained hash key index: sizes, operation codes and node layout.
package chki_pkg;

  localparam int BUCKETS      = 256;
  localparam int POOL_ENTRIES = 1024;

  localparam int KEY_W   = 31;
  localparam int VALUE_W = 32;
  localparam int NKEY_W  = 32;
  localparam int OP_W    = 2;

  // BUCKETS is a power of two, so the bucket is the low key bits.
  localparam int BKT_W  = $clog2(BUCKETS);
  localparam int NODE_W = $clog2(POOL_ENTRIES);
  localparam int FILL_W = $clog2(POOL_ENTRIES + 1);

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
    logic               link_vld;
    logic [NODE_W-1:0]  link;
  } node_t;

  localparam int NODE_BITS = $bits(node_t);

endpackage

// ----- rtl/chained_hash_key_index_unit.sv -----
// Top level of the chained hash key index: bucket heads, node pool and chain walker.
//
//   channel | direction | ports                                            | handshake
//   in      | input     | in_operation, in_key, in_value                   | in_valid/in_ready
//   out     | output    | out_found, out_found_value, out_next_key, out_status | out_valid/out_ready
//
// Insert passes through ST_INS, clear and unused codes go straight to ST_FINISH; a lookup passes
// ST_LK_HEAD, then ST_LK_NODE at one node per cycle, set by the node RAM's single read port.
// Reset clears the bucket valid flops, the pool fill count and the largest key at once.
// A new request is taken once the previous one has left the walker; a result waiting
// on out_ready does not block it, only the hand-over of the next result.
module chained_hash_key_index_unit
  import chki_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [OP_W-1:0]    in_operation,
  input  logic [KEY_W-1:0]   in_key,
  input  logic [VALUE_W-1:0] in_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_found,
  output logic [VALUE_W-1:0] out_found_value,
  output logic [NKEY_W-1:0]  out_next_key,
  output logic               out_status
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_INS     = 3'd1;
  localparam logic [2:0] ST_LK_HEAD = 3'd2;
  localparam logic [2:0] ST_LK_NODE = 3'd3;
  localparam logic [2:0] ST_FINISH  = 3'd4;

  logic [2:0]         state_r, state_nxt;
  logic [BUCKETS-1:0] head_vld_r, head_vld_nxt;
  logic [FILL_W-1:0]  fill_r, fill_nxt;
  logic [KEY_W-1:0]   largest_r, largest_nxt;
  logic [KEY_W-1:0]   key_r, key_nxt;
  logic [VALUE_W-1:0] value_r, value_nxt;
  logic [NODE_W-1:0]  node_addr_r, node_addr_nxt;
  logic               res_found_r, res_found_nxt;
  logic [VALUE_W-1:0] res_value_r, res_value_nxt;
  logic               res_status_r, res_status_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_found_r, out_found_nxt;
  logic [VALUE_W-1:0] out_value_r, out_value_nxt;
  logic [NKEY_W-1:0]  out_nkey_r, out_nkey_nxt;
  logic               out_status_r, out_status_nxt;

  logic [BKT_W-1:0]   bucket_r;
  logic               head_we;
  logic [NODE_W-1:0]  head_rdata;
  logic               node_we;
  node_t              node_wdata;
  logic [NODE_W-1:0]  node_raddr;
  logic [NODE_BITS-1:0] node_rbits;
  node_t              node_rdata;
  logic               pool_full;
  logic               in_acc;

  assign bucket_r   = key_r[BKT_W-1:0];
  assign node_rdata = node_t'(node_rbits);
  assign pool_full  = (fill_r == FILL_W'(POOL_ENTRIES));
  assign in_ready   = (state_r == ST_IDLE);
  assign in_acc     = in_valid && in_ready;

  assign head_we         = (state_r == ST_INS) && !pool_full;
  assign node_we         = head_we;
  assign node_wdata.key      = key_r;
  assign node_wdata.value    = value_r;
  assign node_wdata.link_vld = head_vld_r[bucket_r];
  assign node_wdata.link     = head_rdata;
  assign node_raddr = (state_r == ST_LK_HEAD) ? head_rdata : node_rdata.link;

  chki_ram #(.WIDTH(NODE_W), .DEPTH(BUCKETS)) u_head_ram (
    .clk   (clk),
    .we    (head_we),
    .waddr (bucket_r),
    .wdata (fill_r[NODE_W-1:0]),
    .raddr (in_key[BKT_W-1:0]),
    .rdata (head_rdata)
  );

  chki_ram #(.WIDTH(NODE_BITS), .DEPTH(POOL_ENTRIES)) u_node_ram (
    .clk   (clk),
    .we    (node_we),
    .waddr (fill_r[NODE_W-1:0]),
    .wdata (node_wdata),
    .raddr (node_raddr),
    .rdata (node_rbits)
  );

  always_comb begin
    state_nxt      = state_r;
    head_vld_nxt   = head_vld_r;
    fill_nxt       = fill_r;
    largest_nxt    = largest_r;
    key_nxt        = key_r;
    value_nxt      = value_r;
    node_addr_nxt  = node_addr_r;
    res_found_nxt  = res_found_r;
    res_value_nxt  = res_value_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_found_nxt  = out_found_r;
    out_value_nxt  = out_value_r;
    out_nkey_nxt   = out_nkey_r;
    out_status_nxt = out_status_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          key_nxt        = in_key;
          value_nxt      = in_value;
          res_found_nxt  = 1'b0;
          res_value_nxt  = '0;
          res_status_nxt = 1'b0;
          case (in_operation)
            OP_INSERT: state_nxt = ST_INS;
            OP_LOOKUP: state_nxt = ST_LK_HEAD;
            OP_CLEAR: begin
              head_vld_nxt = '0;
              fill_nxt     = '0;
              state_nxt    = ST_FINISH;
            end
            default: state_nxt = ST_FINISH;
          endcase
        end
      end
      ST_INS: begin
        if (pool_full) begin
          res_status_nxt = 1'b1;
        end else begin
          head_vld_nxt[bucket_r] = 1'b1;
          fill_nxt = fill_r + FILL_W'(1);
          if (key_r > largest_r) begin
            largest_nxt = key_r;
          end
        end
        state_nxt = ST_FINISH;
      end
      ST_LK_HEAD: begin
        if (head_vld_r[bucket_r]) begin
          node_addr_nxt = head_rdata;
          state_nxt     = ST_LK_NODE;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_LK_NODE: begin
        if (node_rdata.key == key_r) begin
          res_found_nxt = 1'b1;
          res_value_nxt = node_rdata.value;
          state_nxt     = ST_FINISH;
        end else if (node_rdata.link_vld) begin
          node_addr_nxt = node_rdata.link;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_found_nxt  = res_found_r;
          out_value_nxt  = res_value_r;
          out_nkey_nxt   = {1'b0, largest_r} + NKEY_W'(1);
          out_status_nxt = res_status_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_vld_r  <= '0;
      fill_r      <= '0;
      largest_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_vld_r  <= head_vld_nxt;
      fill_r      <= fill_nxt;
      largest_r   <= largest_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r        <= key_nxt;
    value_r      <= value_nxt;
    node_addr_r  <= node_addr_nxt;
    res_found_r  <= res_found_nxt;
    res_value_r  <= res_value_nxt;
    res_status_r <= res_status_nxt;
    out_found_r  <= out_found_nxt;
    out_value_r  <= out_value_nxt;
    out_nkey_r   <= out_nkey_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_found_value = out_value_r;
  assign out_next_key    = out_nkey_r;
  assign out_status      = out_status_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(POOL_ENTRIES))
    else $error("pool fill beyond pool size");

  a_walk_written: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LK_NODE) |-> ({1'b0, node_addr_r} < fill_r))
    else $error("chain walk reached an unwritten node");

  a_insert_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_INS && !pool_full) |=> (fill_r == $past(fill_r) + FILL_W'(1)))
    else $error("insert did not take one pool node");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_operation == OP_CLEAR) |=> (fill_r == '0 && head_vld_r == '0))
    else $error("clear left buckets or pool in use");

  a_refused_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_status_r && out_found_r))
    else $error("refused insert reported a hit");

endmodule

// ----- rtl/chki_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module chki_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- tb/chained_hash_key_index_unit_tb.sv -----
// Testbench for the chained hash key index: queued requests, predicted answers, checked results.
module chained_hash_key_index_unit_tb;
  import chki_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int QUIET_TAIL = 150;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } request_t;

  typedef struct packed {
    logic               found;
    logic [VALUE_W-1:0] found_value;
    logic [NKEY_W-1:0]  next_key;
    logic               status;
  } answer_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [OP_W-1:0]    in_operation = '0;
  logic [KEY_W-1:0]   in_key = '0;
  logic [VALUE_W-1:0] in_value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_found;
  logic [VALUE_W-1:0] out_found_value;
  logic [NKEY_W-1:0]  out_next_key;
  logic               out_status;

  chained_hash_key_index_unit uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_key          (in_key),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_found       (out_found),
    .out_found_value (out_found_value),
    .out_next_key    (out_next_key),
    .out_status      (out_status)
  );

  // predicted table contents
  bit                 head_vld [BUCKETS];
  int unsigned        head_idx [BUCKETS];
  logic [KEY_W-1:0]   node_key [POOL_ENTRIES];
  logic [VALUE_W-1:0] node_value [POOL_ENTRIES];
  bit                 node_lvld [POOL_ENTRIES];
  int unsigned        node_link [POOL_ENTRIES];
  int unsigned        pool_used = 0;
  logic [KEY_W-1:0]   top_key = '0;

  request_t         req_q[$];
  answer_t          answer_q[$];
  logic [KEY_W-1:0] key_log[$];
  request_t         cur_req;
  int unsigned      n_total = 0;
  int unsigned      n_sent = 0;
  int unsigned      n_recv = 0;
  int unsigned      n_errors = 0;
  int unsigned      inserts_since_clear = 0;
  int unsigned      src_gap = 0;
  int unsigned      snk_gap = 0;
  int unsigned      src_idle_pct = 15;
  int unsigned      snk_idle_pct = 15;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic answer_t apply_to_index(request_t r);
    answer_t     a;
    int unsigned b;
    int unsigned node;
    int unsigned steps;
    bit          vld;
    a = '0;
    b = r.key % BUCKETS;
    case (r.op)
      OP_INSERT: begin
        if (pool_used >= POOL_ENTRIES) begin
          a.status = 1'b1;
        end else begin
          node_key[pool_used] = r.key;
          node_value[pool_used] = r.value;
          node_lvld[pool_used] = head_vld[b];
          node_link[pool_used] = head_idx[b];
          head_vld[b] = 1'b1;
          head_idx[b] = pool_used;
          pool_used++;
          if (r.key > top_key) top_key = r.key;
        end
      end
      OP_LOOKUP: begin
        vld = head_vld[b];
        node = head_idx[b];
        steps = 0;
        while (vld && steps < POOL_ENTRIES) begin
          if (node_key[node] == r.key) begin
            a.found = 1'b1;
            a.found_value = node_value[node];
            break;
          end
          vld = node_lvld[node];
          node = node_link[node];
          steps++;
        end
      end
      OP_CLEAR: begin
        foreach (head_vld[i]) head_vld[i] = 1'b0;
        pool_used = 0;
      end
      default: ;
    endcase
    a.next_key = NKEY_W'(top_key) + 32'd1;
    return a;
  endfunction

  task automatic add_req(logic [OP_W-1:0] op, logic [KEY_W-1:0] key, logic [VALUE_W-1:0] value);
    request_t r;
    r.op = op;
    r.key = key;
    r.value = value;
    req_q.push_back(r);
    if (op == OP_INSERT) begin
      key_log.push_back(key);
      inserts_since_clear++;
    end else if (op == OP_CLEAR) begin
      inserts_since_clear = 0;
    end
  endtask

  // keys of 4..31 random bits, a quarter packed into eight buckets for long chains
  function automatic logic [KEY_W-1:0] make_key(int unsigned span);
    logic [KEY_W-1:0] k;
    k = KEY_W'($urandom) & ((31'd1 << span) - 31'd1);
    if ($urandom_range(0, 3) == 0) k[BKT_W-1:0] = BKT_W'($urandom_range(0, 7));
    return k;
  endfunction

  task automatic add_random(int unsigned ins_pct, int unsigned clr_pct, int unsigned span);
    int unsigned      roll;
    logic [KEY_W-1:0] k;
    roll = $urandom_range(0, 99);
    k = make_key(span);
    if (roll < ins_pct) begin
      add_req(OP_INSERT, k, $urandom);
    end else if (roll < 98 - clr_pct) begin
      if (key_log.size() > 0 && $urandom_range(0, 2) != 0)
        k = key_log[$urandom_range(0, key_log.size() - 1)];
      add_req(OP_LOOKUP, k, $urandom);
    end else if (roll < 98) begin
      add_req(OP_CLEAR, k, $urandom);
    end else begin
      add_req(OP_UNUSED, k, $urandom);
    end
  endtask

  function automatic int unsigned idle_pick();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 15;
      default: return 40;
    endcase
  endfunction

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        answer_q.push_back(apply_to_index(cur_req));
        n_sent++;
        if (n_sent % 64 == 0) src_idle_pct = idle_pick();
        if (req_q.size() > QUIET_TAIL && $urandom_range(0, 99) < src_idle_pct)
          src_gap = $urandom_range(1, 15);
      end
      if (!in_valid || in_ready) begin
        if (src_gap > 0) begin
          src_gap--;
          in_valid <= 1'b0;
        end else if (req_q.size() > 0) begin
          cur_req = req_q.pop_front();
          in_valid <= 1'b1;
          in_operation <= cur_req.op;
          in_key <= cur_req.key;
          in_value <= cur_req.value;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    answer_t a;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (answer_q.size() == 0) begin
          $display("%0t: unexpected result found=%0d found_value=%h next_key=%h status=%0d",
                   $time, out_found, out_found_value, out_next_key, out_status);
          n_errors++;
        end else begin
          a = answer_q.pop_front();
          if (out_found !== a.found) begin
            $display("%0t: found expected %0d actual %0d", $time, a.found, out_found);
            n_errors++;
          end
          if (out_found_value !== a.found_value) begin
            $display("%0t: found_value expected %h actual %h", $time, a.found_value,
                     out_found_value);
            n_errors++;
          end
          if (out_next_key !== a.next_key) begin
            $display("%0t: next_key expected %h actual %h", $time, a.next_key, out_next_key);
            n_errors++;
          end
          if (out_status !== a.status) begin
            $display("%0t: status expected %0d actual %0d", $time, a.status, out_status);
            n_errors++;
          end
        end
        n_recv++;
        if (n_recv % 64 == 0) snk_idle_pct = idle_pick();
      end
      if (snk_gap > 0) begin
        snk_gap--;
        out_ready <= 1'b0;
      end else if (n_recv + QUIET_TAIL < n_total && $urandom_range(0, 799) < snk_idle_pct) begin
        snk_gap = $urandom_range(0, 14);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    // directed: chain order, shadowing, misses, clear, unused code, field extremes
    add_req(OP_LOOKUP, 31'd0, 32'd0);
    add_req(OP_UNUSED, 31'd5, 32'hFFFF_FFFF);
    add_req(OP_INSERT, 31'd0, 32'd0);
    add_req(OP_LOOKUP, 31'd0, 32'd0);
    add_req(OP_INSERT, 31'd256, 32'hFFFF_FFFF);
    add_req(OP_INSERT, 31'd0, 32'h1234_5678);
    add_req(OP_LOOKUP, 31'd0, 32'd0);
    add_req(OP_LOOKUP, 31'd256, 32'd0);
    add_req(OP_LOOKUP, 31'd512, 32'd0);
    add_req(OP_INSERT, 31'd255, 32'hA5A5_A5A5);
    add_req(OP_LOOKUP, 31'd255, 32'd0);
    add_req(OP_LOOKUP, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
    add_req(OP_INSERT, 31'd3, 32'd1);
    add_req(OP_UNUSED, 31'd0, 32'hFFFF_FFFF);
    add_req(OP_LOOKUP, 31'd3, 32'd0);
    add_req(OP_CLEAR, 31'd0, 32'd0);
    add_req(OP_LOOKUP, 31'd0, 32'd0);
    add_req(OP_LOOKUP, 31'd256, 32'd0);
    add_req(OP_INSERT, 31'd17, 32'h8000_0000);
    add_req(OP_LOOKUP, 31'd17, 32'd0);
    add_req(OP_CLEAR, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
    // mixed traffic, key width growing so the largest key climbs in steps
    for (int i = 0; i < 300; i++)
      add_random(50, 2, (4 + i / 11 > 31) ? 31 : 4 + i / 11);
    // fill the pool and keep inserting past full
    add_req(OP_CLEAR, make_key(31), $urandom);
    while (inserts_since_clear < POOL_ENTRIES + 40)
      add_random(80, 0, 31);
    add_req(OP_CLEAR, make_key(31), $urandom);
    add_req(OP_INSERT, 31'h7FFF_FFFF, $urandom);
    add_req(OP_LOOKUP, 31'h7FFF_FFFF, $urandom);
    add_req(OP_INSERT, 31'h7FFF_FF00, 32'd0);
    add_req(OP_LOOKUP, 31'h7FFF_FF00, $urandom);
    add_req(OP_UNUSED, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
    n_total = req_q.size();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    while (n_sent < n_total || answer_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (n_errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/chki_pkg.sv
rtl/chki_ram.sv
rtl/chained_hash_key_index_unit.sv
tb/chained_hash_key_index_unit_tb.sv
